/* hdl/gip_pkg.sv */
// ----------------------------------------------------------------------------
// gip_pkg
// Shared types and constants for the GPIO interrupt port: request and
// register select codes, data width, pin index width and the default pin count.
// ----------------------------------------------------------------------------
package gip_pkg;

  localparam int unsigned DataWidth   = 32;
  localparam int unsigned PinCountDef = 32;
  localparam int unsigned PinIdxWidth = 5;

  // request kind of one transaction
  typedef enum logic [1:0] {
    REQ_READ      = 2'd0,
    REQ_WRITE     = 2'd1,
    REQ_PIN_EVENT = 2'd2
  } req_e;

  // register select codes
  typedef enum logic [3:0] {
    REG_RST    = 4'd0,
    REG_DAT    = 4'd1,
    REG_DOE    = 4'd2,
    REG_FS0    = 4'd3,
    REG_FS1    = 4'd4,
    REG_FS2    = 4'd5,
    REG_STATUS = 4'd6,
    REG_ENABLE = 4'd7,
    REG_POL    = 4'd8,
    REG_MODE0  = 4'd9,
    REG_MODE1  = 4'd10,
    REG_CTL    = 4'd11
  } reg_e;

endpackage

/* hdl/gpio_interrupt_port.sv */
// ----------------------------------------------------------------------------
// gpio_interrupt_port
// GPIO port with per-pin interrupt detection: bus reads and writes of the
// port registers and pin level change events, one result per transaction.
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake             | payload
//  --------+-----------+-----------------------+-------------------------------
//  in      | input     | in_valid_i/in_stall_o | req_type, reg_sel, write_data,
//          |           |                       | pin_index, pin_level
//  out     | output    | out_valid_o/out_stall_i | read_data, irq
//
//  every transaction passes through the input register and then the result
//  register; a new one is accepted every cycle, limited only by the result
//  register draining
//  the port state is updated when a transaction moves from the input register
//  into the result register, so the next one always sees it
//  reset (rst_ni low, asynchronous) clears all port registers and the valid bits of both stages
//  a stall at the output holds the result and backs up into in_stall_o
//
module gpio_interrupt_port
  import gip_pkg::*;
#(
  parameter int unsigned PIN_COUNT = PinCountDef
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // request channel
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  logic [1:0]             req_type_i,
  input  logic [3:0]             reg_sel_i,
  input  logic [DataWidth-1:0]   write_data_i,
  input  logic [PinIdxWidth-1:0] pin_index_i,
  input  logic                   pin_level_i,
  // result channel
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output logic [DataWidth-1:0]   read_data_o,
  output logic                   irq_o
);

  // input register
  logic                   s1_valid_q;
  logic [1:0]             s1_req_q;
  logic [3:0]             s1_sel_q;
  logic [DataWidth-1:0]   s1_data_q;
  logic [PinIdxWidth-1:0] s1_idx_q;
  logic                   s1_level_q;

  // result register
  logic                 out_valid_q;
  logic [DataWidth-1:0] rdata_q;
  logic                 irq_out_q;

  // port state
  logic [PIN_COUNT-1:0] pin_levels_q, pin_levels_d;
  logic [PIN_COUNT-1:0] status_q, status_d;
  logic [PIN_COUNT-1:0] enable_q, enable_d;
  logic [PIN_COUNT-1:0] pol_q, pol_d;
  logic [PIN_COUNT-1:0] mode_lvl_q, mode_lvl_d;
  logic [PIN_COUNT-1:0] both_edge_q, both_edge_d;
  logic [DataWidth-1:0] fs0_q, fs0_d;
  logic [DataWidth-1:0] ctl_q, ctl_d;
  logic                 irq_line_q, irq_line_d;

  logic                 s2_ready;
  logic                 s1_adv;
  logic                 in_accept;
  logic [DataWidth-1:0] rdata_d;
  logic [PIN_COUNT-1:0] pin_bit;
  logic [PIN_COUNT-1:0] wdata_pins;
  logic [PIN_COUNT-1:0] edge_pins, rise_mask, fall_mask;
  logic [PIN_COUNT-1:0] status_edge;
  logic                 recompute_lvl;

  // result register takes a new transaction when empty or draining
  assign s2_ready   = !out_valid_q || !out_stall_i;
  assign s1_adv     = s1_valid_q && s2_ready;
  assign in_stall_o = s1_valid_q && !s2_ready;
  assign in_accept  = in_valid_i && !in_stall_o;

  // one-hot of the event pin; all zero for a pin beyond the port
  always_comb begin
    for (int i = 0; i < PIN_COUNT; i++) begin
      pin_bit[i] = (s1_idx_q == PinIdxWidth'(i));
    end
  end

  assign wdata_pins = s1_data_q[PIN_COUNT-1:0];

  // edge detection masks from the state before the event
  assign edge_pins = ~mode_lvl_q & enable_q;
  assign rise_mask = edge_pins & (~pol_q | both_edge_q);
  assign fall_mask = edge_pins & (pol_q | both_edge_q);

  // next state and read data
  always_comb begin
    pin_levels_d  = pin_levels_q;
    status_edge   = status_q;
    enable_d      = enable_q;
    pol_d         = pol_q;
    mode_lvl_d    = mode_lvl_q;
    both_edge_d   = both_edge_q;
    fs0_d         = fs0_q;
    ctl_d         = ctl_q;
    rdata_d       = '0;
    recompute_lvl = 1'b0;
    unique case (s1_req_q)
      REQ_READ: begin
        unique case (s1_sel_q)
          REG_DAT:    rdata_d = DataWidth'(pin_levels_q);
          REG_FS0:    rdata_d = fs0_q;
          REG_STATUS: rdata_d = DataWidth'(status_q);
          REG_ENABLE: rdata_d = DataWidth'(enable_q);
          REG_POL:    rdata_d = DataWidth'(pol_q);
          REG_MODE0:  rdata_d = DataWidth'(mode_lvl_q);
          REG_MODE1:  rdata_d = DataWidth'(both_edge_q);
          REG_CTL:    rdata_d = ctl_q;
          default:    rdata_d = '0;
        endcase
      end
      REQ_WRITE: begin
        unique case (s1_sel_q)
          REG_FS0:    fs0_d = s1_data_q;
          REG_STATUS: status_edge = status_q & ~wdata_pins;
          REG_ENABLE: enable_d = wdata_pins;
          REG_POL: begin
            pol_d         = wdata_pins;
            recompute_lvl = 1'b1;
          end
          REG_MODE0: begin
            mode_lvl_d    = wdata_pins;
            recompute_lvl = 1'b1;
          end
          REG_MODE1: begin
            both_edge_d   = wdata_pins;
            recompute_lvl = 1'b1;
          end
          REG_CTL:    ctl_d = s1_data_q;
          default:    ;
        endcase
      end
      REQ_PIN_EVENT: begin
        recompute_lvl = |pin_bit;
        if (s1_level_q) begin
          status_edge  = status_q | (pin_bit & ~pin_levels_q & rise_mask);
          pin_levels_d = pin_levels_q | pin_bit;
        end else begin
          status_edge  = status_q | (pin_bit & pin_levels_q & fall_mask);
          pin_levels_d = pin_levels_q & ~pin_bit;
        end
      end
      default: ;
    endcase

    // level pins follow pin xor polarity
    if (recompute_lvl) begin
      status_d = (status_edge & ~mode_lvl_d) | ((pin_levels_d ^ pol_d) & mode_lvl_d);
    end else begin
      status_d = status_edge;
    end

    // irq is re-evaluated after writes and events, held otherwise
    if (s1_req_q == REQ_WRITE || s1_req_q == REQ_PIN_EVENT) begin
      irq_line_d = |(status_d & enable_d);
    end else begin
      irq_line_d = irq_line_q;
    end
  end

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_accept) begin
      s1_valid_q <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_req_q   <= req_type_i;
      s1_sel_q   <= reg_sel_i;
      s1_data_q  <= write_data_i;
      s1_idx_q   <= pin_index_i;
      s1_level_q <= pin_level_i;
    end
  end

  // port state, updated as a transaction completes its pass
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pin_levels_q <= '0;
      status_q     <= '0;
      enable_q     <= '0;
      pol_q        <= '0;
      mode_lvl_q   <= '0;
      both_edge_q  <= '0;
      fs0_q        <= '0;
      ctl_q        <= '0;
      irq_line_q   <= 1'b0;
    end else if (s1_adv) begin
      pin_levels_q <= pin_levels_d;
      status_q     <= status_d;
      enable_q     <= enable_d;
      pol_q        <= pol_d;
      mode_lvl_q   <= mode_lvl_d;
      both_edge_q  <= both_edge_d;
      fs0_q        <= fs0_d;
      ctl_q        <= ctl_d;
      irq_line_q   <= irq_line_d;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s2_ready) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      rdata_q   <= rdata_d;
      irq_out_q <= irq_line_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign read_data_o = rdata_q;
  assign irq_o       = irq_out_q;

`ifndef ASSERT_OFF
  // irq line always matches the enabled status bits
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    irq_line_q == |(status_q & enable_q))
    else $error("irq line out of step with status and enable");

  // a stall at the input only while the input register is occupied
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> s1_valid_q)
    else $error("input stalled with empty input register");

  // state moves only when a transaction completes
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s1_adv |=> $stable(pin_levels_q) && $stable(status_q))
    else $error("port state changed without a transaction");

  // after a pin event the level pins show pin xor polarity
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_adv && s1_req_q == REQ_PIN_EVENT && (|pin_bit)
    |=> ((status_q ^ pin_levels_q ^ pol_q) & mode_lvl_q) == '0)
    else $error("level pin status not recomputed after event");

  // a completed pass always yields a result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_adv |=> out_valid_o)
    else $error("transaction lost between stages");
`endif

endmodule
